// ===== rtl/core/uer_pkg.sv =====
// uer_pkg: shared widths, codes, reset values and types for the echo ranger
// used by uer_step and ultrasonic_echo_ranger; no dependencies

package uer_pkg;

    localparam int unsigned TickW   = 16;
    localparam int unsigned DistW   = 16;
    localparam int unsigned ErrW    = 2;
    localparam int unsigned PhaseW  = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_CYCLE_TICKS    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SCALE_PER_TICK = 2'd1;

    // reset values
    localparam logic [TickW-1:0] CYCLE_TICKS_RST = 16'd100;
    localparam logic [TickW-1:0] SCALE_RST       = 16'd17;
    localparam logic [TickW-1:0] TICK_RST        = 16'hFFFF;
    localparam logic [TickW-1:0] START_RST       = 16'hFFFF;
    localparam logic [DistW-1:0] DIST_OVERRANGE  = 16'hFFFF;

    // error codes
    localparam logic [ErrW-1:0] ERR_NONE      = 2'd0;
    localparam logic [ErrW-1:0] ERR_NO_ECHO   = 2'd1;
    localparam logic [ErrW-1:0] ERR_OVERRANGE = 2'd2;

    // phase codes as reported on the output
    localparam logic [PhaseW-1:0] CODE_IDLE    = 3'd0;
    localparam logic [PhaseW-1:0] CODE_TRIGGER = 3'd1;
    localparam logic [PhaseW-1:0] CODE_WAIT    = 3'd2;
    localparam logic [PhaseW-1:0] CODE_MEASURE = 3'd3;
    localparam logic [PhaseW-1:0] CODE_FAIL    = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_TRIGGER = 5'b00010,
        PH_WAIT    = 5'b00100,
        PH_MEASURE = 5'b01000,
        PH_FAIL    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [TickW-1:0] tick_count;
        phase_t           phase;
        logic [TickW-1:0] echo_start;
        logic [DistW-1:0] distance;
        logic             trigger;
    } ranger_state_t;

    typedef struct packed {
        logic [TickW-1:0] cycle_ticks;
        logic [TickW-1:0] scale_per_tick;
    } ranger_cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic [DistW-1:0]  distance;
        logic              distance_update;
        logic [ErrW-1:0]   error_event;
        logic [PhaseW-1:0] phase;
    } ranger_result_t;

endpackage

// ===== rtl/core/uer_step.sv =====
// uer_step: per-tick state update and result forming for the echo ranger
// depends on uer_pkg

module uer_step (
    input  uer_pkg::ranger_state_t  state,
    input  uer_pkg::ranger_cfg_t    cfg,
    input  logic                    echo,
    output uer_pkg::ranger_state_t  state_next,
    output uer_pkg::ranger_result_t result
);
    import uer_pkg::*;

    logic [TickW-1:0]   tc;
    logic [TickW-1:0]   width;
    logic [2*TickW-1:0] prod;
    logic [ErrW-1:0]    err;
    logic               upd;
    logic               do_wait;

    assign tc    = state.tick_count + TickW'(1);
    assign width = tc - state.echo_start;
    assign prod  = width * cfg.scale_per_tick;

    always_comb
    begin
        state_next            = state;
        state_next.tick_count = tc;
        err                   = ERR_NONE;
        upd                   = 1'b0;
        do_wait               = 1'b0;

        case (state.phase)
            PH_TRIGGER:
            begin
                if (tc == TickW'(1))
                begin
                    state_next.trigger = 1'b0;
                    state_next.phase   = PH_WAIT;
                    do_wait            = 1'b1;
                end
            end
            PH_WAIT:
            begin
                do_wait = 1'b1;
            end
            PH_MEASURE:
            begin
                if (!echo)
                begin
                    state_next.distance = prod[DistW-1:0];
                    upd                 = 1'b1;
                    state_next.phase    = PH_IDLE;
                end
                else if (tc >= cfg.cycle_ticks)
                begin
                    state_next.phase    = PH_FAIL;
                    err                 = ERR_OVERRANGE;
                    state_next.distance = DIST_OVERRANGE;
                    upd                 = 1'b1;
                end
            end
            PH_FAIL:
            begin
                state_next.phase = PH_IDLE;
            end
            default:
            begin
                state_next.phase = PH_IDLE;
                if (tc == '0)
                begin
                    state_next.trigger = 1'b1;
                    state_next.phase   = PH_TRIGGER;
                end
                else if (tc > cfg.cycle_ticks)
                begin
                    state_next.tick_count = TICK_RST;
                    state_next.echo_start = '0;
                end
            end
        endcase

        // waiting for echo, also entered straight from the trigger phase
        if (do_wait)
        begin
            if (echo)
            begin
                state_next.echo_start = tc;
                state_next.phase      = PH_MEASURE;
            end
            else if (tc == cfg.cycle_ticks)
            begin
                state_next.phase = PH_FAIL;
                err              = ERR_NO_ECHO;
            end
        end
    end

    always_comb
    begin
        result.trigger_level   = state_next.trigger;
        result.distance        = state_next.distance;
        result.distance_update = upd;
        result.error_event     = err;
        case (state_next.phase)
            PH_TRIGGER: result.phase = CODE_TRIGGER;
            PH_WAIT:    result.phase = CODE_WAIT;
            PH_MEASURE: result.phase = CODE_MEASURE;
            PH_FAIL:    result.phase = CODE_FAIL;
            default:    result.phase = CODE_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// ultrasonic_echo_ranger: top level of the ultrasonic echo timer
// depends on uer_pkg and uer_step

// Each input beat is one timer tick carrying the sampled echo level, and each
// tick gives exactly one result beat: trigger drive level, last distance, a
// distance update flag, an error event and the current phase. The block takes
// one beat per clock cycle when the output side is not stalled; a tick passes
// through the input register, then the result register, to the outputs, and
// the state update between them is combinational, with its longest path the
// 16 by 16 multiply of echo width by scale.
// Configuration (cycle_ticks at index 0, scale_per_tick at index 1) is always
// ready and must only be written while no ticks are in flight; other indexes
// are ignored.

module ultrasonic_echo_ranger (
    input  logic                         clk,
    input  logic                         rst_n,

    // tick input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         echo_level,

    // result output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         trigger_level,
    output logic [uer_pkg::DistW-1:0]    distance,
    output logic                         distance_update,
    output logic [uer_pkg::ErrW-1:0]     error_event,
    output logic [uer_pkg::PhaseW-1:0]   phase,

    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [uer_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [uer_pkg::CfgDatW-1:0]  cfg_data
);
    import uer_pkg::*;

    ranger_cfg_t    cfg_reg;
    ranger_state_t  state_reg;
    ranger_state_t  state_next;
    ranger_result_t step_result;
    ranger_result_t result_reg;

    logic in_valid_reg;
    logic echo_reg;
    logic out_valid_reg;
    logic advance;

    // input register moves on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_ticks    <= CYCLE_TICKS_RST;
            cfg_reg.scale_per_tick <= SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CYCLE_TICKS:    cfg_reg.cycle_ticks    <= cfg_data;
                REG_SCALE_PER_TICK: cfg_reg.scale_per_tick <= cfg_data;
                default:            ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            echo_reg <= echo_level;
        end
    end

    uer_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .echo       (echo_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // ranger state, committed as each tick passes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.tick_count <= TICK_RST;
            state_reg.phase      <= PH_IDLE;
            state_reg.echo_start <= START_RST;
            state_reg.distance   <= '0;
            state_reg.trigger    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign trigger_level   = result_reg.trigger_level;
    assign distance        = result_reg.distance;
    assign distance_update = result_reg.distance_update;
    assign error_event     = result_reg.error_event;
    assign phase           = result_reg.phase;

endmodule

// ===== tb/sv/ultrasonic_echo_ranger_tb.sv =====
`timescale 1ns / 1ps
// ultrasonic_echo_ranger_tb: self-checking testbench for the echo ranger, with a small
// scoreboard class that predicts one result beat per accepted tick
// depends on uer_pkg and ultrasonic_echo_ranger

module ultrasonic_echo_ranger_tb;
    import uer_pkg::*;

    // watchdog, far beyond the slowest legal run
    localparam int unsigned CycleLimit  = 200_000;
    // length of the one long output hold-off that backs the block up
    localparam int unsigned HoldCycles  = 64;
    // ticks in the randomised middle part
    localparam int unsigned RandomTicks = 1100;

    // indexes past the last register, which the block must ignore
    localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 2'd3;

    // directed echo levels, first tick in the msb, with the limit at 3 and full scale:
    // immediate echo on the tick after the trigger, product wrap, a no-echo timeout,
    // then an echo still high at the limit (overrange)
    localparam logic [16:0] DirectedEchoes = 17'b11100000000001100;

    // how the echo line behaves over one measurement cycle
    typedef enum logic [1:0] {
        PLAN_PULSE,
        PLAN_SILENT,
        PLAN_NOISE
    } echo_plan_t;

    class ranging_scoreboard;
        logic [TickW-1:0]  cycle_ticks;
        logic [TickW-1:0]  scale_per_tick;
        logic [TickW-1:0]  tick_count;
        logic [PhaseW-1:0] phase;
        logic [TickW-1:0]  echo_start;
        logic [DistW-1:0]  distance;
        logic              trigger;
        ranger_result_t    due_readings[$];
        int unsigned       mismatches;

        function new();
            cycle_ticks    = CYCLE_TICKS_RST;
            scale_per_tick = SCALE_RST;
            tick_count     = TICK_RST;
            phase          = CODE_IDLE;
            echo_start     = START_RST;
            distance       = '0;
            trigger        = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] index, logic [CfgDatW-1:0] data);
            case (index)
                REG_CYCLE_TICKS:    cycle_ticks = data;
                REG_SCALE_PER_TICK: scale_per_tick = data;
                default:            ;
            endcase
        endfunction

        // waiting for the rising echo edge, or for the timeout at the limit
        function logic [ErrW-1:0] look_for_echo(logic echo);
            if (echo)
            begin
                echo_start = tick_count;
                phase      = CODE_MEASURE;
            end
            else if (tick_count == cycle_ticks)
            begin
                phase = CODE_FAIL;
                return ERR_NO_ECHO;
            end
            return ERR_NONE;
        endfunction

        function void note_tick(logic echo);
            ranger_result_t beat;
            beat.distance_update = 1'b0;
            beat.error_event     = ERR_NONE;
            tick_count++;
            case (phase)
                CODE_TRIGGER:
                    if (tick_count == 16'd1)
                    begin
                        trigger          = 1'b0;
                        phase            = CODE_WAIT;
                        beat.error_event = look_for_echo(echo);
                    end
                CODE_WAIT:
                    beat.error_event = look_for_echo(echo);
                CODE_MEASURE:
                    if (!echo)
                    begin
                        // width and product both wrap at 16 bits
                        distance             = (tick_count - echo_start) * scale_per_tick;
                        beat.distance_update = 1'b1;
                        phase                = CODE_IDLE;
                    end
                    else if (tick_count >= cycle_ticks)
                    begin
                        phase                = CODE_FAIL;
                        beat.error_event     = ERR_OVERRANGE;
                        distance             = DIST_OVERRANGE;
                        beat.distance_update = 1'b1;
                    end
                CODE_FAIL:
                    phase = CODE_IDLE;
                default:
                begin
                    phase = CODE_IDLE;
                    if (tick_count == '0)
                    begin
                        trigger = 1'b1;
                        phase   = CODE_TRIGGER;
                    end
                    else if (tick_count > cycle_ticks)
                    begin
                        tick_count = TICK_RST;
                        echo_start = '0;
                    end
                end
            endcase
            beat.trigger_level = trigger;
            beat.distance      = distance;
            beat.phase         = phase;
            due_readings.push_back(beat);
        endfunction

        function void compare_field(string field, logic [DistW-1:0] want,
                                    logic [DistW-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(ranger_result_t got);
            ranger_result_t want;
            if (due_readings.size() == 0)
            begin
                $error("result beat with no tick outstanding");
                mismatches++;
                return;
            end
            want = due_readings.pop_front();
            compare_field("trigger_level", want.trigger_level, got.trigger_level);
            compare_field("distance", want.distance, got.distance);
            compare_field("distance_update", want.distance_update, got.distance_update);
            compare_field("error_event", want.error_event, got.error_event);
            compare_field("phase", want.phase, got.phase);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                echo_level;
    logic                out_valid;
    logic                out_stall;
    logic                trigger_level;
    logic [DistW-1:0]    distance;
    logic                distance_update;
    logic [ErrW-1:0]     error_event;
    logic [PhaseW-1:0]   phase;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDatW-1:0]  cfg_data;

    ranging_scoreboard   sb;
    int unsigned         cycle_count = 0;

    // idling control shared by the tick sender and the result stall process
    logic                gaps_on  = 1'b1;
    logic                quiet    = 1'b0;
    logic                hold_req = 1'b0;

    // echo shaping for the current measurement cycle
    echo_plan_t          plan       = PLAN_PULSE;
    int unsigned         plan_delay = 0;
    int unsigned         plan_width = 1;
    int unsigned         wait_ticks = 0;
    int unsigned         high_ticks = 0;

    ultrasonic_echo_ranger i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .echo_level      (echo_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .trigger_level   (trigger_level),
        .distance        (distance),
        .distance_update (distance_update),
        .error_event     (error_event),
        .phase           (phase),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // picks the echo level of the next tick from the predicted phase, so that most
    // cycles see a clean pulse: a delay after the trigger, then a high stretch;
    // a silent cycle only runs when the timeout is near, noise is bounded too
    function automatic logic choose_echo();
        logic echo;
        echo = 1'($urandom_range(1));
        case (sb.phase)
            CODE_TRIGGER, CODE_WAIT:
            begin
                case (plan)
                    PLAN_PULSE:  echo = (wait_ticks >= plan_delay);
                    PLAN_SILENT: echo = !(sb.cycle_ticks > sb.tick_count
                                          && sb.cycle_ticks - sb.tick_count < 300);
                    default:     if (wait_ticks > 64) echo = 1'b1;
                endcase
                wait_ticks++;
            end
            CODE_MEASURE:
            begin
                if (plan != PLAN_NOISE)
                    echo = (high_ticks < plan_width);
                else if (high_ticks > 64)
                    echo = 1'b0;
                high_ticks++;
            end
            default:
            begin
                // idle or fail: the level is ignored, set up the next cycle
                wait_ticks = 0;
                high_ticks = 0;
                case ($urandom_range(9))
                    0:       plan = PLAN_SILENT;
                    1:       plan = PLAN_NOISE;
                    default: plan = PLAN_PULSE;
                endcase
                plan_delay = ($urandom_range(5) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(0, 12);
                plan_width = $urandom_range(1, 48);
            end
        endcase
        return echo;
    endfunction

    // one tick beat; the payload holds while the block stalls
    task automatic send_tick(input logic echo);
        if (gaps_on && $urandom_range(7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        echo_level <= echo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_tick(echo);
        @(negedge clk);
    endtask

    // one register write, valid left high for a following write
    task automatic cfg_put(input logic [CfgIdxW-1:0] index, input logic [CfgDatW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(index, data);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [TickW-1:0] limit, input logic [TickW-1:0] scale);
        cfg_put(REG_CYCLE_TICKS, limit);
        cfg_put(REG_SCALE_PER_TICK, scale);
        // now and then a write to an unused index, which must change nothing
        if ($urandom_range(1))
            cfg_put($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // drain, reprogram while nothing is in flight, then a run of shaped ticks
    task automatic run_phase(input logic [TickW-1:0] limit, input logic [TickW-1:0] scale,
                             input int unsigned ticks, input logic squeeze);
        in_valid <= 1'b0;
        while (sb.due_readings.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        set_regs(limit, scale);
        gaps_on  = !quiet && ($urandom_range(4) != 0);
        hold_req = squeeze;
        repeat (ticks) send_tick(choose_echo());
    endtask

    // result side stall: short random bursts, or the single long hold-off
    initial
    begin : result_stall
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HoldCycles - 1) @(negedge clk);
            end
            else if (gaps_on && $urandom_range(5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // every accepted result beat is checked against the oldest prediction
    always @(posedge clk)
    begin : result_check
        ranger_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.trigger_level   = trigger_level;
            got.distance        = distance;
            got.distance_update = distance_update;
            got.error_event     = error_event;
            got.phase           = phase;
            sb.check_beat(got);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned      random_ticks;
        int unsigned      ticks;
        logic [TickW-1:0] limit;
        logic [TickW-1:0] scale;
        logic             pressed;

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        echo_level = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_CYCLE_TICKS;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk through every phase and both error events
        set_regs(16'd3, 16'hFFFF);
        for (int i = 16; i >= 0; i--)
            send_tick(DirectedEchoes[i]);

        // limits at and below the bottom of the range, zero scale
        run_phase(16'd0, 16'd17, 40, 1'b0);
        run_phase(16'd1, 16'd0, 40, 1'b0);
        run_phase(16'd2, 16'($urandom), 60, 1'b0);

        // randomised middle part, mostly short cycles so that every phase recurs often
        random_ticks = 0;
        pressed      = 1'b0;
        while (random_ticks < RandomTicks)
        begin
            ticks = $urandom_range(80, 250);
            limit = ($urandom_range(7) == 0) ? 16'($urandom_range(41, 300))
                                             : 16'($urandom_range(2, 40));
            scale = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 40))
                                             : 16'($urandom);
            run_phase(limit, scale, ticks, !pressed);
            pressed      = 1'b1;
            random_ticks += ticks;
        end

        // top of the range and just below it
        run_phase(16'hFFFF, 16'hFFFF, 100, 1'b0);
        run_phase(16'hFFFE, 16'($urandom), 100, 1'b0);

        // last part at full rate, no idling on either side
        quiet = 1'b1;
        run_phase(16'd5, 16'($urandom), 150, 1'b0);

        in_valid <= 1'b0;
        while (sb.due_readings.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (sb.mismatches == 0 && sb.due_readings.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
